>>> hw/rtl/cbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbm_pkg: shared types and constants of the cartridge bank mapper
// Item structs, target and mode codes, register masks and address widths.
// ----------------------------------------------------------------------------
package cbm_pkg;

  localparam int RamAddrBits = 20;
  localparam int RomAddrBits = 24;
  localparam int MemAddrW    = 24;
  localparam int NumRegs     = 16;
  localparam int RegIdxW     = $clog2(NumRegs);

  localparam logic [MemAddrW-1:0] RamAddrMask = MemAddrW'((64'd1 << RamAddrBits) - 64'd1);
  localparam logic [MemAddrW-1:0] RomAddrMask = MemAddrW'((64'd1 << RomAddrBits) - 64'd1);

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    TGT_NONE  = 2'd0,
    TGT_FLASH = 2'd1,
    TGT_RAM   = 2'd2,
    TGT_REG   = 2'd3
  } target_t;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_FLASH  = 2'd1,
    MODE_RAM_RO = 2'd2,
    MODE_RAM_RW = 2'd3
  } mode_t;

  localparam logic [RegIdxW-1:0] RegCtrl    = 4'd0;
  localparam logic [RegIdxW-1:0] RegCfgLow  = 4'd1;
  localparam logic [RegIdxW-1:0] RegCfgBlk  = 4'd2;
  localparam logic [RegIdxW-1:0] RegSpare   = 4'd3;
  localparam logic [RegIdxW-1:0] BankRam123 = 4'd4;
  localparam logic [RegIdxW-1:0] BankIo     = 4'd6;
  localparam logic [RegIdxW-1:0] BankBlk1   = 4'd8;
  localparam logic [RegIdxW-1:0] BankBlk2   = 4'd10;
  localparam logic [RegIdxW-1:0] BankBlk3   = 4'd12;
  localparam logic [RegIdxW-1:0] BankBlk5   = 4'd14;

  localparam logic [7:0] CfgBlkReset = 8'h40;
  localparam logic [7:0] IoOffBit    = 8'h80;

  typedef struct packed {
    opcode_t    opcode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  video_bus_last;
    logic [7:0]  cpu_bus_last;
  } req_t;

  typedef struct packed {
    target_t             target;
    logic [MemAddrW-1:0] mem_address;
    logic                mem_write;
    logic [7:0]          mem_data;
    logic [7:0]          read_data;
    logic                drives_bus;
  } rsp_t;

  function automatic logic [7:0] reg_mask(input logic [RegIdxW-1:0] idx);
    logic [7:0] m;
    unique case (idx)
      RegCtrl:   m = 8'h81;
      RegCfgLow: m = 8'h3f;
      RegCfgBlk: m = 8'hff;
      RegSpare:  m = 8'h00;
      default:   m = idx[0] ? 8'h07 : 8'hff;
    endcase
    return m;
  endfunction

endpackage

>>> hw/rtl/cartridge_bank_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_mapper: host bus window decode and bank address mapping
// Decodes one bus access per item, keeps the sixteen mapper registers and
// issues a flash, RAM, register or no-target result.
// ----------------------------------------------------------------------------
//   channel | dir | handshake           | payload
//   req     | in  | req_valid/req_ready | cbm_pkg::req_t
//   rsp     | out | rsp_valid/rsp_ready | cbm_pkg::rsp_t
//
// One item per cycle unless rsp stalls; rsp_valid rises the cycle after
// acceptance. Decode and bank add are done in the accepting cycle and land
// in the result register. A stalled result still takes a new item in the
// cycle it is consumed. Reset and register writes load the mapper registers.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cbm_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output cbm_pkg::rsp_t rsp
);

  logic [7:0] mapper_regs [cbm_pkg::NumRegs];
  logic       accept;
  logic       wr;
  logic       io;
  logic       mapped;
  logic       reg_wr;
  logic [cbm_pkg::RegIdxW-1:0] breg;
  logic [cbm_pkg::RegIdxW-1:0] ridx;
  cbm_pkg::mode_t mode;
  logic [cbm_pkg::MemAddrW-1:0] sum;
  cbm_pkg::rsp_t rsp_next;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign wr        = (req.opcode == cbm_pkg::OP_WRITE);
  assign ridx      = req.address[cbm_pkg::RegIdxW-1:0];

  assign sum = {mapper_regs[breg + 4'd1][2:0], mapper_regs[breg], 13'b0}
             + {11'b0, req.address[12:0]};

  always_comb begin
    rsp_next    = '0;
    mode        = cbm_pkg::MODE_OFF;
    breg        = cbm_pkg::BankRam123;
    io          = 1'b0;
    mapped      = 1'b1;
    reg_wr      = 1'b0;
    if (req.address >= 16'h0400 && req.address <= 16'h0fff) begin
      mode = cbm_pkg::mode_t'(mapper_regs[cbm_pkg::RegCfgLow][1:0]);
      breg = cbm_pkg::BankRam123;
    end else if (req.address >= 16'h2000 && req.address <= 16'h3fff) begin
      mode = cbm_pkg::mode_t'(mapper_regs[cbm_pkg::RegCfgBlk][1:0]);
      breg = cbm_pkg::BankBlk1;
    end else if (req.address >= 16'h4000 && req.address <= 16'h7fff) begin
      if (req.address[13]) begin
        mode = cbm_pkg::mode_t'(mapper_regs[cbm_pkg::RegCfgBlk][5:4]);
        breg = cbm_pkg::BankBlk3;
      end else begin
        mode = cbm_pkg::mode_t'(mapper_regs[cbm_pkg::RegCfgBlk][3:2]);
        breg = cbm_pkg::BankBlk2;
      end
    end else if (req.address >= 16'ha000 && req.address <= 16'hbfff) begin
      mode = cbm_pkg::mode_t'(mapper_regs[cbm_pkg::RegCfgBlk][7:6]);
      breg = cbm_pkg::BankBlk5;
    end else if (req.address >= 16'h9800 && req.address <= 16'h9fff) begin
      mapped = 1'b0;
      if ((mapper_regs[cbm_pkg::RegCtrl] & cbm_pkg::IoOffBit) != 8'h00) begin
        rsp_next.read_data = wr ? 8'h00 : req.cpu_bus_last;
      end else if ((req.address[10:0] & 11'h7f0) == 11'h3f0) begin
        rsp_next.target = cbm_pkg::TGT_REG;
        if (wr) begin
          reg_wr = 1'b1;
        end else begin
          rsp_next.read_data  = mapper_regs[ridx];
          rsp_next.drives_bus = 1'b1;
        end
      end else begin
        mapped = 1'b1;
        io     = 1'b1;
        breg   = cbm_pkg::BankIo;
        mode   = req.address[9] ? cbm_pkg::mode_t'(mapper_regs[cbm_pkg::RegCfgLow][5:4])
                                : cbm_pkg::mode_t'(mapper_regs[cbm_pkg::RegCfgLow][3:2]);
      end
    end else begin
      mapped = 1'b0;
      rsp_next.read_data = wr ? 8'h00 : req.video_bus_last;
    end

    if (mapped) begin
      if (mode == cbm_pkg::MODE_OFF || (wr && mode == cbm_pkg::MODE_RAM_RO)) begin
        rsp_next.read_data = wr ? 8'h00 : req.video_bus_last;
      end else begin
        if (mode == cbm_pkg::MODE_FLASH) begin
          rsp_next.target      = cbm_pkg::TGT_FLASH;
          rsp_next.mem_address = sum & cbm_pkg::RomAddrMask;
        end else begin
          rsp_next.target      = cbm_pkg::TGT_RAM;
          rsp_next.mem_address = sum & cbm_pkg::RamAddrMask;
        end
        rsp_next.mem_write  = wr;
        rsp_next.mem_data   = wr ? req.write_data : 8'h00;
        rsp_next.drives_bus = !wr && io;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cbm_pkg::NumRegs; i++) begin
        mapper_regs[i] <= 8'h00;
      end
      mapper_regs[cbm_pkg::RegCfgBlk] <= cbm_pkg::CfgBlkReset;
    end else if (accept && reg_wr) begin
      mapper_regs[ridx] <= cbm_pkg::reg_mask(ridx) & req.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  a_io_off_sticky: assert property (@(posedge clk) disable iff (rst)
    mapper_regs[cbm_pkg::RegCtrl][7] |=> mapper_regs[cbm_pkg::RegCtrl][7])
    else $error("I/O disable bit cleared without reset");

  a_reg3_zero: assert property (@(posedge clk) disable iff (rst)
    mapper_regs[cbm_pkg::RegSpare] == 8'h00)
    else $error("unused mapper register holds nonzero bits");

  a_ram_addr_width: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.target == cbm_pkg::TGT_RAM |->
      (rsp.mem_address & ~cbm_pkg::RamAddrMask) == '0)
    else $error("RAM address exceeds RAM width");

  a_write_no_drive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.mem_write |-> !rsp.drives_bus && rsp.read_data == 8'h00)
    else $error("memory write drives the bus");

  a_none_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.target == cbm_pkg::TGT_NONE || rsp.target == cbm_pkg::TGT_REG) |->
      rsp.mem_address == '0 && !rsp.mem_write && rsp.mem_data == 8'h00)
    else $error("memory request fields set without memory target");

endmodule
